>>> src/rcem_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcem_pkg
// Shared constants and types for the Roberts cross edge magnitude block.
// ----------------------------------------------------------------------------
package rcem_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_CHANNELS = 4;
    localparam int STORE_DEPTH  = MAX_WIDTH * MAX_CHANNELS;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int CH_W         = $clog2(MAX_CHANNELS);

    localparam int SAMPLE_W     = 8;
    localparam int LW_W         = 11;
    localparam int CC_W         = 3;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = LW_W;

    // sum of two squared 9-bit differences
    localparam int SUM_W        = 17;
    localparam int MAG_MAX      = 255;

    localparam int Q_DEPTH      = 4;
    localparam int Q_PTR_W      = $clog2(Q_DEPTH);
    localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);

    localparam logic [LW_W-1:0] LW_RESET = LW_W'(640);
    localparam logic [CC_W-1:0] CC_RESET = CC_W'(3);

    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = CFG_IDX_W'(1);

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             row_end;
    } t_job;

endpackage

>>> src/rcem_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcem_ram
// Single-port-write, single-port-read RAM with registered, read-first output.
// ----------------------------------------------------------------------------
module rcem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/rcem_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcem_fifo
// Short job queue between the front end and the square root unit.
// ----------------------------------------------------------------------------
module rcem_fifo
    import rcem_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  t_job               i_job,
    input  logic               i_pop,
    output t_job               o_head,
    output logic [Q_CNT_W-1:0] o_count
);

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

>>> src/rcem_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcem_front
// Raster tracking, line store access and gradient squares; queues one job
// per sample (pixel position and channel) that has a full 2x2 neighborhood.
// ----------------------------------------------------------------------------
module rcem_front
    import rcem_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_push,
    input  logic [SAMPLE_W-1:0]   i_sample,
    input  logic                  i_frame_start,
    output logic                  o_full,
    input  logic [Q_CNT_W-1:0]    i_q_count,
    output logic                  o_q_push,
    output t_job                  o_q_job
);

    logic [LW_W-1:0]     r_line_width;
    logic [CC_W-1:0]     r_chan_count;
    logic [COL_W-1:0]    r_col, n_col;
    logic [CH_W-1:0]     r_ch, n_ch;
    logic                r_past_row, n_past_row;

    logic                r_s1_valid;
    logic                r_s1_res;
    logic                r_s1_row_end;
    logic [CH_W-1:0]     r_s1_ch;
    logic [SAMPLE_W-1:0] r_s1_cur;
    logic [SAMPLE_W-1:0] r_left [MAX_CHANNELS];
    logic [SAMPLE_W-1:0] r_upl  [MAX_CHANNELS];

    logic [LW_W-1:0]     w_eff;
    logic [CC_W-1:0]     nch_eff;
    logic                accept;
    logic [COL_W-1:0]    col_eff;
    logic [CH_W-1:0]     ch_eff;
    logic                past_eff;
    logic [ADDR_W-1:0]   addr;
    logic                has_res;
    logic                row_end;
    logic [CC_W-1:0]     ch_inc;
    logic [LW_W-1:0]     col_inc;
    logic [SAMPLE_W-1:0] upper;
    logic signed [SAMPLE_W:0]     gx, gy;
    logic        [2*SAMPLE_W-1:0] gx_sq, gy_sq;
    logic [Q_CNT_W:0]    q_need;

    // clamp the registers to their legal ranges
    always_comb begin
        w_eff = r_line_width;
        if (r_line_width < LW_W'(2)) begin
            w_eff = LW_W'(2);
        end else if (r_line_width > LW_W'(MAX_WIDTH)) begin
            w_eff = LW_W'(MAX_WIDTH);
        end
        nch_eff = r_chan_count;
        if (r_chan_count < CC_W'(1)) begin
            nch_eff = CC_W'(1);
        end else if (r_chan_count > CC_W'(MAX_CHANNELS)) begin
            nch_eff = CC_W'(MAX_CHANNELS);
        end
    end

    // reserve a queue slot for the job that may still sit in stage 1
    assign q_need = (Q_CNT_W + 1)'(i_q_count) + (Q_CNT_W + 1)'(r_s1_valid & r_s1_res);
    assign o_full = q_need >= (Q_CNT_W + 1)'(Q_DEPTH);
    assign accept = i_push && !o_full;

    always_comb begin
        col_eff  = r_col;
        ch_eff   = r_ch;
        past_eff = r_past_row;
        if (i_frame_start || LW_W'(r_col) >= w_eff) begin
            col_eff = '0;
        end
        if (i_frame_start || CC_W'(r_ch) >= nch_eff) begin
            ch_eff = '0;
        end
        if (i_frame_start) begin
            past_eff = 1'b0;
        end

        addr    = ADDR_W'(col_eff) * ADDR_W'(nch_eff) + ADDR_W'(ch_eff);
        has_res = past_eff && (col_eff != '0);
        row_end = (LW_W'(col_eff) == w_eff - 1'b1) && (CC_W'(ch_eff) == nch_eff - 1'b1);

        // advance channel, then column, then row
        n_col      = col_eff;
        n_ch       = ch_eff;
        n_past_row = past_eff;
        ch_inc     = CC_W'(ch_eff) + 1'b1;
        col_inc    = LW_W'(col_eff) + 1'b1;
        if (ch_inc >= nch_eff) begin
            n_ch = '0;
            if (col_inc >= w_eff) begin
                n_col      = '0;
                n_past_row = 1'b1;
            end else begin
                n_col = col_inc[COL_W-1:0];
            end
        end else begin
            n_ch = ch_inc[CH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LW_RESET;
            r_chan_count <= CC_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LINE_WIDTH:    r_line_width <= i_cfg_data[LW_W-1:0];
                REG_CHANNEL_COUNT: r_chan_count <= i_cfg_data[CC_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_ch       <= '0;
            r_past_row <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            if (accept) begin
                r_col      <= n_col;
                r_ch       <= n_ch;
                r_past_row <= n_past_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_res     <= has_res;
            r_s1_row_end <= row_end;
            r_s1_ch      <= ch_eff;
            r_s1_cur     <= i_sample;
        end
    end

    // read and write the same entry: the registered read returns the old row
    rcem_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (STORE_DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (addr),
        .i_wdata (i_sample),
        .i_raddr (addr),
        .o_rdata (upper)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_left[i] <= '0;
                r_upl[i]  <= '0;
            end
        end else if (r_s1_valid) begin
            r_left[r_s1_ch] <= r_s1_cur;
            r_upl[r_s1_ch]  <= upper;
        end
    end

    always_comb begin
        gx    = $signed({1'b0, r_upl[r_s1_ch]}) - $signed({1'b0, r_s1_cur});
        gy    = $signed({1'b0, upper}) - $signed({1'b0, r_left[r_s1_ch]});
        // widen before squaring so the product keeps all its bits
        gx_sq = (2*SAMPLE_W)'(gx) * (2*SAMPLE_W)'(gx);
        gy_sq = (2*SAMPLE_W)'(gy) * (2*SAMPLE_W)'(gy);
    end

    assign o_q_push        = r_s1_valid && r_s1_res;
    assign o_q_job.sum     = SUM_W'(gx_sq) + SUM_W'(gy_sq);
    assign o_q_job.row_end = r_s1_row_end;

endmodule

>>> src/rcem_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcem_back
// Bit-pair square root, one step per cycle while not stalled, with saturation
// and a result register toward the output side; only the final step stalls.
// ----------------------------------------------------------------------------
module rcem_back
    import rcem_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [Q_CNT_W-1:0]  i_q_count,
    input  t_job                i_q_head,
    output logic                o_q_pop,
    output logic                o_empty,
    input  logic                i_pop,
    output logic [SAMPLE_W-1:0] o_magnitude,
    output logic                o_row_end
);

    localparam logic [SUM_W-1:0] BIT_TOP = SUM_W'(1) << (SUM_W - 1);

    logic                r_busy;
    logic [SUM_W-1:0]    r_rem;
    logic [SUM_W-1:0]    r_root;
    logic [SUM_W-1:0]    r_bit;
    logic                r_job_row_end;
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_mag;
    logic                r_out_row_end;

    logic [SUM_W-1:0]    trial;
    logic                fits;
    logic [SUM_W-1:0]    n_rem;
    logic [SUM_W-1:0]    n_root;
    logic                last;
    logic                out_free;
    logic                stall;

    always_comb begin
        trial  = r_root + r_bit;
        fits   = r_rem >= trial;
        n_rem  = fits ? r_rem - trial : r_rem;
        n_root = fits ? (r_root >> 1) + r_bit : (r_root >> 1);
    end

    assign last     = r_bit[0];
    assign out_free = !r_out_valid || i_pop;
    // hold the final step until the result register frees up
    assign stall    = r_busy && last && !out_free;
    assign o_q_pop  = !r_busy && (i_q_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_busy <= 1'b1;
            end else if (r_busy && last && !stall) begin
                r_busy <= 1'b0;
            end
            if (r_busy && last && !stall) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_rem         <= i_q_head.sum;
            r_root        <= '0;
            r_bit         <= BIT_TOP;
            r_job_row_end <= i_q_head.row_end;
        end else if (r_busy && !stall) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_bit  <= r_bit >> 2;
        end
        if (r_busy && last && !stall) begin
            r_out_mag     <= (n_root > SUM_W'(MAG_MAX)) ? SAMPLE_W'(MAG_MAX)
                                                        : n_root[SAMPLE_W-1:0];
            r_out_row_end <= r_job_row_end;
        end
    end

    assign o_empty     = !r_out_valid;
    assign o_magnitude = r_out_mag;
    assign o_row_end   = r_out_row_end;

endmodule

>>> src/roberts_cross_edge_magnitude.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roberts_cross_edge_magnitude
// Roberts cross edge magnitude over a channel-interleaved raster stream.
// ----------------------------------------------------------------------------
// An accepted sample passes stage 1, the job queue, the square root steps and
// the result register on its way to the ports, waiting longer while jobs queue.
// Throughput: one sample per cycle while the job queue has room; results are
// paced by the 9-step shared square root unit, which takes one job at a time.
// Reset (synchronous, active low) clears counters, queue and result register;
// registers return to 640 pixels and 3 channels. No clearing pass is needed.
// ----------------------------------------------------------------------------
module roberts_cross_edge_magnitude
    import rcem_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic [SAMPLE_W-1:0]   i_sample,
    input  logic                  i_frame_start,
    output logic                  empty,
    input  logic                  pop,
    output logic [SAMPLE_W-1:0]   o_magnitude,
    output logic                  o_row_end
);

    logic               q_push;
    logic               q_pop;
    t_job               q_job;
    t_job               q_head;
    logic [Q_CNT_W-1:0] q_count;

    rcem_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_push        (push),
        .i_sample      (i_sample),
        .i_frame_start (i_frame_start),
        .o_full        (full),
        .i_q_count     (q_count),
        .o_q_push      (q_push),
        .o_q_job       (q_job)
    );

    rcem_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_job),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_count (q_count)
    );

    rcem_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_count   (q_count),
        .i_q_head    (q_head),
        .o_q_pop     (q_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_magnitude (o_magnitude),
        .o_row_end   (o_row_end)
    );

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= Q_CNT_W'(Q_DEPTH))
        else $error("job queue over capacity");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && !q_pop && q_count == Q_CNT_W'(Q_DEPTH)))
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_count != '0)
        else $error("job taken from an empty queue");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_push && !q_pop) |=> q_count == $past(q_count) + 1'b1)
        else $error("queue count did not advance on a push");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Roberts cross edge magnitude block. Streams
// channel-interleaved frames through the push/full port under several line
// geometries, predicts every magnitude and row-end flag on the side, and
// compares each popped beat against the oldest prediction. Both handshakes
// idle at random.
// ----------------------------------------------------------------------------
module testbench;
    import rcem_pkg::*;

    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 360;

    typedef struct packed {
        logic [SAMPLE_W-1:0] mag;
        logic                rend;
    } t_edge_result;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                fs;
        logic                pinned;
        logic [SAMPLE_W-1:0] mag;
        logic                rend;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = REG_LINE_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  push = 1'b0;
    logic                  full;
    logic [SAMPLE_W-1:0]   i_sample = '0;
    logic                  i_frame_start = 1'b0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [SAMPLE_W-1:0]   o_magnitude;
    logic                  o_row_end;

    // shadow of the block: geometry registers and pixel history
    logic [LW_W-1:0]     width_reg = LW_RESET;
    logic [CC_W-1:0]     chan_reg = CC_RESET;
    logic [SAMPLE_W-1:0] line_mem [STORE_DEPTH];
    logic [SAMPLE_W-1:0] left_px [MAX_CHANNELS];
    logic [SAMPLE_W-1:0] upleft_px [MAX_CHANNELS];
    int                  col_pos = 0;
    int                  chan_pos = 0;
    logic                past_first = 1'b0;

    t_edge_result expected_edges[$];
    int           mismatch_count = 0;
    int           random_items = 0;
    int           gap_pct = 25;
    int           stall_pct = 25;
    int           pop_hold = 0;
    int           cycle_count = 0;
    t_stim_row    directed_rows [0:22];

    roberts_cross_edge_magnitude u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .push          (push),
        .full          (full),
        .i_sample      (i_sample),
        .i_frame_start (i_frame_start),
        .empty         (empty),
        .pop           (pop),
        .o_magnitude   (o_magnitude),
        .o_row_end     (o_row_end)
    );

    always #1 i_clk = ~i_clk;

    function automatic int eff_width();
        if (width_reg < 2) return 2;
        if (width_reg > MAX_WIDTH) return MAX_WIDTH;
        return int'(width_reg);
    endfunction

    function automatic int eff_chans();
        if (chan_reg < 1) return 1;
        if (chan_reg > MAX_CHANNELS) return MAX_CHANNELS;
        return int'(chan_reg);
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Advance the shadow by one sample; returns 1 when the sample yields a magnitude.
    function automatic logic predict_edge(input logic [SAMPLE_W-1:0] s, input logic fs,
                                          output t_edge_result res);
        int w;
        int n;
        int idx;
        int gx;
        int gy;
        int sum;
        int root;
        int trial;
        logic [SAMPLE_W-1:0] above;
        logic hit;
        w = eff_width();
        n = eff_chans();
        hit = 1'b0;
        res = '0;
        if (fs) begin
            col_pos = 0;
            chan_pos = 0;
            past_first = 1'b0;
        end
        if (chan_pos >= n) chan_pos = 0;
        if (col_pos >= w) col_pos = 0;
        idx = col_pos * n + chan_pos;
        above = line_mem[idx];
        if (past_first && col_pos >= 1) begin
            gx = int'(upleft_px[chan_pos]) - int'(s);
            gy = int'(above) - int'(left_px[chan_pos]);
            sum = gx * gx + gy * gy;
            // build the root one bit at a time, largest first
            root = 0;
            for (int b = 8; b >= 0; b--) begin
                trial = root | (1 << b);
                if (trial * trial <= sum) root = trial;
            end
            res.mag = (root > MAG_MAX) ? SAMPLE_W'(MAG_MAX) : SAMPLE_W'(root);
            res.rend = (col_pos == w - 1) && (chan_pos == n - 1);
            hit = 1'b1;
        end
        upleft_px[chan_pos] = above;
        left_px[chan_pos] = s;
        line_mem[idx] = s;
        chan_pos++;
        if (chan_pos >= n) begin
            chan_pos = 0;
            col_pos++;
            if (col_pos >= w) begin
                col_pos = 0;
                past_first = 1'b1;
            end
        end
        return hit;
    endfunction

    // Call at a falling edge; returns at a falling edge after the beat is taken.
    task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic fs,
                               input logic pinned, input logic [SAMPLE_W-1:0] pmag,
                               input logic prend);
        int gap;
        t_edge_result res;
        logic hit;
        gap = ($urandom_range(0, 99) < gap_pct) ? pick_gap() : 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push <= 1'b1;
        i_sample <= s;
        i_frame_start <= fs;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        hit = predict_edge(s, fs, res);
        if (pinned) begin
            res.mag = pmag;
            res.rend = prend;
            expected_edges.push_back(res);
        end else if (hit) begin
            expected_edges.push_back(res);
        end
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (expected_edges.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_geometry(input int w, input int c);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= REG_LINE_WIDTH;
        i_cfg_data <= CFG_DATA_W'(w);
        @(negedge i_clk);
        i_cfg_idx <= REG_CHANNEL_COUNT;
        i_cfg_data <= CFG_DATA_W'(c);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        width_reg = LW_W'(w);
        chan_reg = CC_W'(c);
    endtask

    task automatic pick_pace();
        gap_pct = ($urandom_range(0, 3) == 0) ? 0 : 25;
        stall_pct = ($urandom_range(0, 3) == 0) ? 0 : 25;
    endtask

    // Mostly whole frames; now and then cut short or restarted midway.
    task automatic run_frame(input int rows);
        int total;
        int cut;
        int restart_at;
        total = rows * eff_width() * eff_chans();
        cut = total;
        restart_at = -1;
        if ($urandom_range(0, 9) == 0) cut = $urandom_range(1, total - 1);
        if ($urandom_range(0, 9) == 0) restart_at = $urandom_range(1, total - 1);
        // stop once the random budget is spent
        for (int k = 0; k < cut && random_items < RANDOM_ITEMS; k++) begin
            send_sample(pick_sample(), (k == 0) || (k == restart_at), 1'b0, '0, 1'b0);
            random_items++;
        end
    endtask

    // receiver: hold pop low for random stretches
    always @(negedge i_clk) begin
        if (pop_hold != 0) begin
            pop <= 1'b0;
            pop_hold <= pop_hold - 1;
        end else begin
            pop <= 1'b1;
            if ($urandom_range(0, 99) < stall_pct) pop_hold <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (expected_edges.size() == 0) begin
                $display("%0t: unexpected beat, magnitude %0d row_end %0b",
                         $time, o_magnitude, o_row_end);
                mismatch_count++;
            end else begin
                if (o_magnitude !== expected_edges[0].mag) begin
                    $display("%0t: magnitude expected %0d actual %0d",
                             $time, expected_edges[0].mag, o_magnitude);
                    mismatch_count++;
                end
                if (o_row_end !== expected_edges[0].rend) begin
                    $display("%0t: row_end expected %0b actual %0b",
                             $time, expected_edges[0].rend, o_row_end);
                    mismatch_count++;
                end
                void'(expected_edges.pop_front());
            end
        end
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("roberts_cross_edge_magnitude regression: fail");
        $finish;
    end

    initial begin
        int forced_w [5];
        int forced_c [5];
        int phase;
        int w;
        int c;
        int rows;
        forced_w = '{0, 1, 3, 2, 4};
        forced_c = '{7, 5, 6, 0, 4};
        foreach (line_mem[k]) line_mem[k] = '0;
        foreach (left_px[k]) begin
            left_px[k] = '0;
            upleft_px[k] = '0;
        end
        // 2x2 blocks at two pixels per row, one channel
        directed_rows = '{
            '{8'd255, 1'b1, 1'b0, 8'd0,   1'b0},
            '{8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
            '{8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
            '{8'd0,   1'b0, 1'b1, 8'd255, 1'b1},   // saturates
            '{8'd0,   1'b1, 1'b0, 8'd0,   1'b0},
            '{8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
            '{8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
            '{8'd0,   1'b0, 1'b1, 8'd0,   1'b1},   // flat
            '{8'd0,   1'b1, 1'b0, 8'd0,   1'b0},
            '{8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
            '{8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
            '{8'd0,   1'b0, 1'b1, 8'd255, 1'b1},   // exactly full scale
            '{8'd1,   1'b1, 1'b0, 8'd0,   1'b0},
            '{8'd1,   1'b0, 1'b0, 8'd0,   1'b0},
            '{8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
            '{8'd0,   1'b0, 1'b1, 8'd1,   1'b1},   // root of two floors
            '{8'd10,  1'b0, 1'b0, 8'd0,   1'b0},
            '{8'd20,  1'b0, 1'b1, 8'd22,  1'b1},   // third row
            '{8'd100, 1'b1, 1'b0, 8'd0,   1'b0},
            '{8'd7,   1'b1, 1'b0, 8'd0,   1'b0},   // restart mid-row
            '{8'd8,   1'b0, 1'b0, 8'd0,   1'b0},
            '{8'd9,   1'b0, 1'b0, 8'd0,   1'b0},
            '{8'd10,  1'b0, 1'b1, 8'd3,   1'b1}
        };

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // power-on geometry: a few pixels of row 0, none of which yields a beat
        pick_pace();
        for (int k = 0; k < 12; k++) send_sample(pick_sample(), k == 0, 1'b0, '0, 1'b0);
        wait_idle();

        set_geometry(2, 1);
        foreach (directed_rows[k])
            send_sample(directed_rows[k].sample, directed_rows[k].fs, directed_rows[k].pinned,
                        directed_rows[k].mag, directed_rows[k].rend);
        wait_idle();

        // shrink the geometry inside row 0 where both counters wrap to zero
        set_geometry(8, 3);
        for (int k = 0; k < 17; k++) send_sample(pick_sample(), k == 0, 1'b0, '0, 1'b0);
        wait_idle();
        set_geometry(3, 2);
        for (int k = 0; k < 18; k++) send_sample(pick_sample(), 1'b0, 1'b0, '0, 1'b0);
        wait_idle();

        // both registers past their limits: 1024 pixels, one channel; one row
        // and the start of the next
        set_geometry(11'h7FF, 0);
        pick_pace();
        for (int k = 0; k < MAX_WIDTH + 4; k++) send_sample(pick_sample(), k == 0, 1'b0, '0, 1'b0);
        wait_idle();

        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            if (phase < 5) begin
                w = forced_w[phase];
                c = forced_c[phase];
            end else begin
                if ($urandom_range(0, 19) == 0) w = $urandom_range(0, 1);
                else if ($urandom_range(0, 4) == 0) w = $urandom_range(13, 48);
                else w = $urandom_range(2, 12);
                c = $urandom_range(0, 7);
            end
            set_geometry(w, c);
            pick_pace();
            repeat ($urandom_range(1, 2)) begin
                rows = (eff_width() > 12) ? 2 : $urandom_range(2, 4);
                run_frame(rows);
            end
            wait_idle();
            phase++;
        end

        if (mismatch_count == 0) begin
            $display("roberts_cross_edge_magnitude regression: pass");
        end else begin
            $display("roberts_cross_edge_magnitude regression: fail");
        end
        $finish;
    end

endmodule
